FILE: rtl/jfc_pkg.sv
package jfc_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // Configuration register map
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_LEVEL = 2'd1;

  // Register reset levels, truncated to the sample width where used
  localparam int MIN_LEVEL_RESET = 0;
  localparam int MAX_LEVEL_RESET = 4095;

  // Sideband carried alongside each sample through the pipeline
  typedef struct packed {
    logic clip;   // result must report clamping
    logic zero;   // t forced to 0
    logic full;   // t forced to 1.0
  } flags_t;

endpackage

FILE: rtl/jfc_div_pipe.sv
module jfc_div_pipe #(
  parameter int SAMPLE_WIDTH  = jfc_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = jfc_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] min_level_i,
  input  logic signed [SAMPLE_WIDTH-1:0] max_level_i,
  input  logic        [SAMPLE_WIDTH-1:0] range_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic        [FRACTION_BITS:0]  quot_o,
  output jfc_pkg::flags_t                flags_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int TW = FRACTION_BITS + 1;
  // stage 0 takes the sample, stages 1..TW each resolve one quotient bit
  localparam int NS = TW + 1;
  localparam logic [TW-1:0] UNIT = TW'(1) << FRACTION_BITS;

  logic [NS-1:0]   v_q;
  logic [NS-1:0]   adv;
  logic [SW-1:0]   rem_q [NS];
  logic [TW-1:0]   q_q   [NS];
  jfc_pkg::flags_t fl_q  [NS];

  // Front end: offset from min level and range checks
  logic signed [SW:0] smp_x, min_x, max_x, diff_x;
  logic               below, above, inval;
  jfc_pkg::flags_t    fl_in;
  logic [SW-1:0]      rem_in;

  always_comb begin
    smp_x  = {sample_i[SW-1], sample_i};
    min_x  = {min_level_i[SW-1], min_level_i};
    max_x  = {max_level_i[SW-1], max_level_i};
    diff_x = smp_x - min_x;
    inval  = (max_x <= min_x);
    below  = (smp_x < min_x);
    above  = (smp_x > max_x);
    fl_in.zero = inval || below;
    fl_in.full = !(inval || below) && above;
    fl_in.clip = inval || below || above;
    rem_in = fl_in.clip ? '0 : diff_x[SW-1:0];
  end

  // Stage advance: a stage moves when empty or when its successor moves
  assign adv[NS-1] = !v_q[NS-1] || out_ready_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign in_ready_o = adv[0];

  // One restoring division step per stage
  logic [SW:0]   tr_w  [1:NS-1];
  logic [NS-1:1] qbit;
  logic [SW-1:0] rem_d [1:NS-1];

  always_comb begin
    for (int k = 1; k < NS; k++) begin
      // first step compares the offset itself, later ones the doubled remainder
      tr_w[k]  = (k == 1) ? {1'b0, rem_q[k-1]} : {rem_q[k-1], 1'b0};
      qbit[k]  = (tr_w[k] >= {1'b0, range_i});
      rem_d[k] = qbit[k] ? SW'(tr_w[k] - {1'b0, range_i}) : tr_w[k][SW-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rem_q[0] <= rem_in;
      q_q[0]   <= '0;
      fl_q[0]  <= fl_in;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        rem_q[k] <= rem_d[k];
        q_q[k]   <= {q_q[k-1][TW-2:0], qbit[k]};
        fl_q[k]  <= fl_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign quot_o      = q_q[NS-1];
  assign flags_o     = fl_q[NS-1];

`ifndef NO_ASSERTIONS
  // an in-range sample never yields a fraction above 1.0
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !fl_q[NS-1].zero && !fl_q[NS-1].full |-> q_q[NS-1] <= UNIT)
    else $error("quotient above unit");

  // forcing to zero and to full never coincide
  a_force_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> !(fl_q[0].zero && fl_q[0].full))
    else $error("conflicting force flags");

  // a forced fraction always reports clamping
  a_force_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && (fl_q[NS-1].zero || fl_q[NS-1].full) |-> fl_q[NS-1].clip)
    else $error("forced fraction without clip flag");
`endif

endmodule

FILE: rtl/jfc_colormap.sv
module jfc_colormap #(
  parameter int FRACTION_BITS = jfc_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FRACTION_BITS:0]   quot_i,
  input  jfc_pkg::flags_t          flags_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o,
  output logic                     clipped_o
);

  localparam int F  = FRACTION_BITS;
  localparam int TW = F + 1;
  localparam int NW = F + 3;
  localparam int PW = TW + 8;

  // segment limits on t
  localparam logic [TW-1:0] UNIT = TW'(1) << F;
  localparam logic [TW-1:0] T1   = TW'(1) << (F - 3);
  localparam logic [TW-1:0] T3   = TW'(3) << (F - 3);
  localparam logic [TW-1:0] T5   = TW'(5) << (F - 3);
  localparam logic [TW-1:0] T7   = TW'(7) << (F - 3);
  // ramp offsets in halves of unit
  localparam logic [NW-1:0] H1   = NW'(1) << (F - 1);
  localparam logic [NW-1:0] H3   = NW'(3) << (F - 1);
  localparam logic [NW-1:0] H5   = NW'(5) << (F - 1);
  localparam logic [NW-1:0] H7   = NW'(7) << (F - 1);
  localparam logic [NW-1:0] H9   = NW'(9) << (F - 1);
  localparam logic [NW-1:0] UNW  = NW'(1) << F;

  logic          va_q, vb_q, adv_a, adv_b;
  logic [TW-1:0] r_num_q, g_num_q, b_num_q;
  logic          clip_a_q;

  assign adv_b      = !vb_q || out_ready_i;
  assign adv_a      = !va_q || adv_b;
  assign in_ready_o = adv_a;

  // Stage A: final t, segment decode and ramp numerators
  logic [TW-1:0] t_w;
  logic [NW-1:0] t4, r_num, g_num, b_num;

  always_comb begin
    t_w = flags_i.full ? UNIT : (flags_i.zero ? '0 : quot_i);
    t4  = {t_w, 2'b00};
    r_num = '0;
    g_num = '0;
    b_num = '0;
    priority if (t_w <= T1) begin
      b_num = t4 + H1;
    end else if (t_w <= T3) begin
      g_num = t4 - H1;
      b_num = UNW;
    end else if (t_w <= T5) begin
      r_num = t4 - H3;
      g_num = UNW;
      b_num = H5 - t4;
    end else if (t_w <= T7) begin
      r_num = UNW;
      g_num = H7 - t4;
    end else begin
      r_num = H9 - t4;
    end
  end

  // Stage B: scale by 255, floor and saturate
  function automatic logic [7:0] chan(input logic [TW-1:0] num);
    logic [PW-1:0] prod;
    logic [8:0]    c;
    prod = {num, 8'b0} - {8'b0, num};
    c    = prod[PW-1:F];
    return (c > 9'd255) ? 8'hFF : c[7:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= in_valid_i;
      if (adv_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      r_num_q  <= TW'(r_num);
      g_num_q  <= TW'(g_num);
      b_num_q  <= TW'(b_num);
      clip_a_q <= flags_i.clip;
    end
    if (adv_b) begin
      red_o     <= chan(r_num_q);
      green_o   <= chan(g_num_q);
      blue_o    <= chan(b_num_q);
      clipped_o <= clip_a_q;
    end
  end

  assign out_valid_o = vb_q;

`ifndef NO_ASSERTIONS
  // a blocked stage A holds its numerators
  a_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q && !adv_a |=> va_q && $stable(r_num_q) && $stable(g_num_q) && $stable(b_num_q))
    else $error("stage A lost its contents under stall");
`endif

endmodule

FILE: rtl/jet_false_color_mapper.sv
// Channel   Direction  Handshake                      Payload
// sample    in         sample_valid_i / sample_ready_o sample_i
// cfg       in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
// result    out        result_valid_o / result_ready_i red_o, green_o, blue_o, clipped_o
//
// One sample per cycle sustained while results are accepted; each result passes one input
// stage, FRACTION_BITS + 1 divider stages that resolve one quotient bit each, and two
// colormap stages.
// Reset clears all valid bits and loads min 0, max 4095.
// A stalled result freezes only the stages behind it that are full; bubbles close up,
// so samples keep being taken while any stage is empty.
module jet_false_color_mapper #(
  parameter int SAMPLE_WIDTH  = jfc_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = jfc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [jfc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index_i,
  input  logic [SAMPLE_WIDTH-1:0]              cfg_data_i,
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic [7:0]                           red_o,
  output logic [7:0]                           green_o,
  output logic [7:0]                           blue_o,
  output logic                                 clipped_o
);

  localparam int SW = SAMPLE_WIDTH;

  logic signed [SW-1:0] min_q, max_q;
  logic        [SW-1:0] range_q;

  assign cfg_ready_o = 1'b1;

  // Level registers and the derived range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= SW'(jfc_pkg::MIN_LEVEL_RESET);
      max_q   <= SW'(jfc_pkg::MAX_LEVEL_RESET);
      range_q <= SW'(jfc_pkg::MAX_LEVEL_RESET - jfc_pkg::MIN_LEVEL_RESET);
    end else begin
      range_q <= SW'(max_q - min_q);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          jfc_pkg::CFG_MIN_LEVEL: min_q <= cfg_data_i;
          jfc_pkg::CFG_MAX_LEVEL: max_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  logic                 div_valid, div_ready;
  logic [FRACTION_BITS:0] div_quot;
  jfc_pkg::flags_t      div_flags;

  jfc_div_pipe #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_valid_i),
    .in_ready_o  (sample_ready_o),
    .sample_i    (sample_i),
    .min_level_i (min_q),
    .max_level_i (max_q),
    .range_i     (range_q),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .quot_o      (div_quot),
    .flags_o     (div_flags)
  );

  jfc_colormap #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .quot_i      (div_quot),
    .flags_i     (div_flags),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .clipped_o   (clipped_o)
  );

endmodule

FILE: tb/sv/tb_jet_false_color_mapper.sv
`timescale 1ns / 100ps

module tb_jet_false_color_mapper;

  localparam int SW = jfc_pkg::SAMPLE_WIDTH_DEF;
  localparam int FB = jfc_pkg::FRACTION_BITS_DEF;
  localparam int IW = jfc_pkg::CFG_INDEX_WIDTH;
  localparam int LATENCY = FB + 4;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // Indexes past the register map; writes there must leave both levels alone
  localparam logic [IW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [IW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 clip;
  } colour_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        sample_valid_i = 1'b0;
  logic                        sample_ready_o;
  logic signed [SW-1:0]        sample_i       = '0;
  logic                        cfg_valid_i    = 1'b0;
  logic                        cfg_ready_o;
  logic [IW-1:0]               cfg_index_i    = jfc_pkg::CFG_MIN_LEVEL;
  logic [SW-1:0]               cfg_data_i     = '0;
  logic                        result_valid_o;
  logic                        result_ready_i = 1'b0;
  logic [7:0]                  red_o;
  logic [7:0]                  green_o;
  logic [7:0]                  blue_o;
  logic                        clipped_o;

  // Local copy of the level registers, tracked from cfg transactions
  logic signed [SW-1:0] lvl_min = SW'(jfc_pkg::MIN_LEVEL_RESET);
  logic signed [SW-1:0] lvl_max = SW'(jfc_pkg::MAX_LEVEL_RESET);

  colour_t pending_colours[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;
  int rx_stall   = 0;

  jet_false_color_mapper dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .clipped_o      (clipped_o)
  );

  always #6 clk_i = ~clk_i;

  // 255 * num in Q1.FB, floored and saturated
  function automatic logic [7:0] sat_channel(input longint num);
    longint c;
    c = (255 * num) >>> FB;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  // Jet colour of one sample against the current levels
  function automatic colour_t jet_colour(input logic signed [SW-1:0] s, lo, hi);
    longint  u, t, sv, lov, hiv;
    colour_t c;
    u   = longint'(1) << FB;
    sv  = s;
    lov = lo;
    hiv = hi;
    c = '0;
    c.sample = s;
    if (hiv <= lov) begin
      t = 0;
      c.clip = 1'b1;
    end else if (sv < lov) begin
      t = 0;
      c.clip = 1'b1;
    end else if (sv > hiv) begin
      t = u;
      c.clip = 1'b1;
    end else begin
      t = ((sv - lov) << FB) / (hiv - lov);
      if (t > u) t = u;
    end
    if (t <= u / 8) begin
      c.blue = sat_channel(4 * t + u / 2);
    end else if (t <= 3 * u / 8) begin
      c.green = sat_channel(4 * t - u / 2);
      c.blue  = 8'd255;
    end else if (t <= 5 * u / 8) begin
      c.red   = sat_channel(4 * t - 3 * u / 2);
      c.green = 8'd255;
      c.blue  = sat_channel(5 * u / 2 - 4 * t);
    end else if (t <= 7 * u / 8) begin
      c.red   = 8'd255;
      c.green = sat_channel(7 * u / 2 - 4 * t);
    end else begin
      c.red   = sat_channel(9 * u / 2 - 4 * t);
    end
    return c;
  endfunction

  // Mostly inside the range, some around its edges, the rest anywhere
  function automatic logic signed [SW-1:0] random_sample(
    input logic signed [SW-1:0] lo, hi
  );
    int span, pick;
    span = int'(hi) - int'(lo);
    pick = $urandom_range(0, 99);
    if (pick < 70 && span > 0)
      return SW'(int'(lo) + int'($urandom_range(0, span)));
    else if (pick < 78)
      return SW'(int'(lo) + int'($urandom_range(0, 4)) - 2);
    else if (pick < 86)
      return SW'(int'(hi) + int'($urandom_range(0, 4)) - 2);
    else
      return SW'($urandom);
  endfunction

  // Input monitor: level writes and expected colours per sample transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lvl_min <= SW'(jfc_pkg::MIN_LEVEL_RESET);
      lvl_max <= SW'(jfc_pkg::MAX_LEVEL_RESET);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          jfc_pkg::CFG_MIN_LEVEL: lvl_min <= cfg_data_i;
          jfc_pkg::CFG_MAX_LEVEL: lvl_max <= cfg_data_i;
          default: ;
        endcase
      end
      if (sample_valid_i && sample_ready_o)
        pending_colours.push_back(jet_colour(sample_i, lvl_min, lvl_max));
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    colour_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (pending_colours.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result r=%0d g=%0d b=%0d clip=%0b",
                   $realtime, red_o, green_o, blue_o, clipped_o);
        mismatches++;
      end else begin
        want = pending_colours.pop_front();
        if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue ||
            clipped_o !== want.clip) begin
          if (mismatches < 10)
            $display({"%0t: sample %0d: expected r=%0d g=%0d b=%0d clip=%0b, ",
                      "got r=%0d g=%0d b=%0d clip=%0b"},
                     $realtime, want.sample, want.red, want.green, want.blue, want.clip,
                     red_o, green_o, blue_o, clipped_o);
          mismatches++;
        end
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
      rx_stall       <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done      <= 1'b1;
      rx_stall       <= LONG_HOLD - 1;
      result_ready_i <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall       <= rx_stall - 1;
      result_ready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_stall       <= $urandom_range(0, 6);
      result_ready_i <= 1'b0;
    end else begin
      result_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_valid_i && sample_ready_o) || (cfg_valid_i && cfg_ready_o) ||
          (result_valid_o && result_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding",
                 $realtime, pending_colours.size());
        $display("tb_jet_false_color_mapper NOT OK");
        $finish;
      end
    end
  end

  // One sample transaction; valid stays high for a following back-to-back item
  task automatic send_sample(input logic signed [SW-1:0] s);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      sample_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (!(sample_valid_i && sample_ready_o));
  endtask

  task automatic write_level(input logic [IW-1:0] idx, input logic [SW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering samples and let the pipeline empty
  task automatic drain_results();
    sample_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_colours.size() != 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Reset levels 0..4095: segment boundaries, both ends and one step past each end
  task automatic test_reset_levels();
    logic signed [SW-1:0] pts[12];
    pts = '{16'sd0, 16'sd511, 16'sd512, 16'sd1535, 16'sd1536, 16'sd2559,
            16'sd2560, 16'sd3583, 16'sd3584, 16'sd4095, 16'sd4096, -16'sd1};
    foreach (pts[i]) send_sample(pts[i]);
    drain_results();
  endtask

  // Widest range, sample at both extremes; equal to max is not clipped
  task automatic test_full_scale();
    write_level(jfc_pkg::CFG_MIN_LEVEL, 16'h8000);
    write_level(jfc_pkg::CFG_MAX_LEVEL, 16'h7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    drain_results();
  endtask

  // Max equal to min and max below min both give t=0 with the flag
  task automatic test_invalid_range();
    write_level(jfc_pkg::CFG_MIN_LEVEL, 16'd1000);
    write_level(jfc_pkg::CFG_MAX_LEVEL, 16'd1000);
    send_sample(16'sd1000);
    send_sample(16'sh8000);
    drain_results();
    write_level(jfc_pkg::CFG_MIN_LEVEL, 16'h7FFF);
    write_level(jfc_pkg::CFG_MAX_LEVEL, 16'h8000);
    send_sample(16'sd0);
    send_sample(16'sh7FFF);
    drain_results();
  endtask

  // Range of one step: below, at min, at max, above
  task automatic test_narrow_range();
    write_level(jfc_pkg::CFG_MIN_LEVEL, 16'd100);
    write_level(jfc_pkg::CFG_MAX_LEVEL, 16'd101);
    send_sample(16'sd99);
    send_sample(16'sd100);
    send_sample(16'sd101);
    send_sample(16'sd102);
    drain_results();
  endtask

  // Writes past the register map are dropped
  task automatic test_ignored_index();
    write_level(CFG_SPARE_LO, 16'h8000);
    write_level(CFG_SPARE_HI, 16'h7FFF);
    send_sample(16'sd100);
    send_sample(16'sd101);
    drain_results();
  endtask

  // Random level pair, with a bias towards useful ranges
  task automatic random_levels();
    logic signed [SW-1:0] lo, hi;
    case ($urandom_range(0, 3))
      0: begin
        lo = SW'($urandom);
        hi = SW'($urandom);
      end
      1: begin
        lo = SW'($urandom);
        hi = SW'(int'(lo) + int'($urandom_range(1, 64)));
      end
      2: begin
        lo = SW'($urandom_range(0, 16383) - 16384);
        hi = SW'($urandom_range(1, 16384));
      end
      default: begin
        lo = 16'sh8000;
        hi = 16'sh7FFF;
      end
    endcase
    write_level(jfc_pkg::CFG_MIN_LEVEL, lo);
    write_level(jfc_pkg::CFG_MAX_LEVEL, hi);
  endtask

  task automatic random_burst(input int count);
    repeat (count) begin
      send_sample(random_sample(lvl_min, lvl_max));
    end
    drain_results();
  endtask

  // Random phases, each with its own levels and idling pattern
  task automatic test_random();
    repeat (5) begin
      random_levels();
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      random_burst(180);
    end
  endtask

  // Receiver holds off for a long stretch while samples keep coming
  task automatic test_back_pressure();
    random_levels();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    hold_req   <= 1'b1;
    random_burst(120);
  endtask

  // Closing part at full rate on both sides
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    random_levels();
    random_burst(160);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_levels();
    test_full_scale();
    test_invalid_range();
    test_narrow_range();
    test_ignored_index();
    test_random();
    test_back_pressure();
    test_full_rate();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_colours.size() == 0) begin
      $display("tb_jet_false_color_mapper OK");
    end else begin
      $display("tb_jet_false_color_mapper NOT OK");
    end
    $finish;
  end

endmodule

FILE: jet_false_color_mapper.f
rtl/jfc_pkg.sv
rtl/jfc_div_pipe.sv
rtl/jfc_colormap.sv
rtl/jet_false_color_mapper.sv
tb/sv/tb_jet_false_color_mapper.sv
